>>> hw/rtl/tam_pkg.sv
// ----------------------------------------------------------------------------
// tam_pkg
// Shared types, constants and helpers for the tilt-rotor actuator mixer.
// ----------------------------------------------------------------------------
package tam_pkg;

  localparam int unsigned PulseBitsDef = 12;
  localparam int unsigned FracBits     = 14;
  localparam int unsigned NumCh        = 9;
  localparam int unsigned NumReg       = 8;
  localparam int unsigned CmdW         = 16;
  localparam int unsigned OutW         = 12;
  localparam int unsigned IdxW         = 3;
  localparam int unsigned CfgW         = 64;

  // ceil(2^26 / 5): exact floor divide by five for dividends below 2^26
  localparam logic [23:0] RecipFive    = 24'hCCCCCD;

  typedef enum logic [1:0] {
    ModeDisarmed   = 2'd0,
    ModeHover      = 2'd1,
    ModeCruise     = 2'd2,
    ModeTransition = 2'd3
  } mode_e;

  typedef enum logic [IdxW-1:0] {
    RegMotor   = 3'd0,
    RegTiltL   = 3'd1,
    RegTiltR   = 3'd2,
    RegAilL    = 3'd3,
    RegAilR    = 3'd4,
    RegRudder  = 3'd5,
    RegFlapL   = 3'd6,
    RegFlapR   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [CmdW-1:0] thr;
    logic signed [CmdW-1:0] roll;
    logic signed [CmdW-1:0] pitch;
    logic signed [CmdW-1:0] yaw;
    logic signed [CmdW-1:0] flap;
    logic signed [CmdW-1:0] tilt;
  } cmd_t;

endpackage

>>> hw/rtl/tam_front.sv
// ----------------------------------------------------------------------------
// tam_front
// Accepts command words, clamps throttle, roll, pitch and yaw and hands them to a short queue.
// ----------------------------------------------------------------------------
module tam_front import tam_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic valid_o,
  output cmd_t cmd_o
);
  localparam logic signed [CmdW+1:0] One = (CmdW+2)'(1) <<< FracBits;

  function automatic logic signed [CmdW-1:0] clamp(input logic signed [CmdW-1:0] v,
                                                     input logic signed [CmdW+1:0] lo);
    logic signed [CmdW+1:0] e;
    logic signed [CmdW+1:0] r;
    e = (CmdW+2)'(v);
    r = e;
    if (e < lo) r = lo;
    if (e > One) r = One;
    return r[CmdW-1:0];
  endfunction

  logic valid_q;
  cmd_t cmd_q;

  // small queue of depth one; back end always drains at one word a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= push_i;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q.mode  <= cmd_i.mode;
      cmd_q.thr   <= clamp(cmd_i.thr, '0);
      cmd_q.roll  <= clamp(cmd_i.roll, -One);
      cmd_q.pitch <= clamp(cmd_i.pitch, -One);
      cmd_q.yaw   <= clamp(cmd_i.yaw, -One);
      cmd_q.flap  <= cmd_i.flap;
      cmd_q.tilt  <= cmd_i.tilt;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
endmodule

>>> hw/rtl/tam_servo.sv
// ----------------------------------------------------------------------------
// tam_servo
// Maps a normalized value (scaled by 10 * 2^F) onto one servo; the product is registered.
// ----------------------------------------------------------------------------
module tam_servo import tam_pkg::*; #(
  parameter int unsigned PulseBits = PulseBitsDef
) (
  input  logic                    clk_i,
  input  logic [3*PulseBits:0]    cal_i,
  input  logic signed [23:0]      n_i,
  output logic [PulseBits-1:0]    us_o
);
  localparam int unsigned PW = PulseBits;
  localparam int unsigned NW = 42;
  localparam longint Den = 10 * (64'sd1 << FracBits);

  logic [PW-1:0] mn, ctr, mx;
  logic signed [24:0] v;
  logic signed [PW+1:0] span;
  logic signed [NW-1:0] prod_q;
  logic [PW-1:0] mn_q, ctr_q, mx_q;
  logic signed [NW-1:0] num, q;
  logic signed [NW-1:0] us;
  logic [25:0] qa;
  logic [49:0] qp;

  assign mn  = cal_i[PW-1:0];
  assign ctr = cal_i[2*PW-1:PW];
  assign mx  = cal_i[3*PW-1:2*PW];
  assign v   = cal_i[3*PW] ? -25'(n_i) : 25'(n_i);
  assign span = (v >= 0) ? ($signed({2'b0, mx}) - $signed({2'b0, ctr}))
                         : ($signed({2'b0, ctr}) - $signed({2'b0, mn}));

  always_ff @(posedge clk_i) begin
    prod_q <= NW'(v) * NW'(span);
    mn_q <= mn;
    ctr_q <= ctr;
    mx_q <= mx;
  end

  // divide by 5 * 2^(F+1): shift, then reciprocal multiply by five.
  // A negative numerator ends at the lower limit after the clamps, so use zero.
  assign num = NW'($signed({1'b0, ctr_q})) * NW'(Den) + prod_q;
  assign qa  = 26'(num >>> (FracBits + 1));
  assign qp  = qa * RecipFive;
  assign q   = (num < 0) ? '0 : NW'(qp[49:26]);

  always_comb begin
    us = q;
    if (us < NW'($signed({1'b0, mn_q}))) us = NW'($signed({1'b0, mn_q}));
    if (us > NW'($signed({1'b0, mx_q}))) us = NW'($signed({1'b0, mx_q}));
  end

  assign us_o = us[PW-1:0];
endmodule

>>> hw/rtl/tam_back.sv
// ----------------------------------------------------------------------------
// tam_back
// Hover and cruise mixing, actuator mapping, the transition blend and per-mode output select.
// ----------------------------------------------------------------------------
module tam_back import tam_pkg::*; #(
  parameter int unsigned PulseBits = PulseBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  cmd_t                     cmd_i,
  input  logic [4*PulseBits-1:0]   motor_cal_i,
  input  logic [3*PulseBits:0]     servo_cal_i [1:NumReg-1],
  output logic                     valid_o,
  output logic [OutW-1:0]          ch_o [NumCh]
);
  localparam int unsigned PW = PulseBits;
  localparam int signed   OneQ = 1 << FracBits;
  localparam int signed   Den  = 10 * OneQ;

  // stage 1: mixed normalized values (hover h*, cruise c*)
  logic signed [23:0] thr, roll, pitch, yaw, flap, tiltraw;
  logic signed [23:0] diff, hml, hmr, hp3, hr5, hy5, hp5;
  logic signed [23:0] cail, cair;
  logic signed [23:0] n_h [NumCh];
  logic signed [23:0] n_c [NumCh];

  function automatic logic signed [23:0] clampn(input logic signed [23:0] a);
    logic signed [23:0] r;
    r = a;
    if (a < -24'(Den)) r = -24'(Den);
    if (a > 24'(Den)) r = 24'(Den);
    return r;
  endfunction

  function automatic logic signed [23:0] clamp0(input logic signed [23:0] a);
    logic signed [23:0] r;
    r = a;
    if (a < 0) r = '0;
    if (a > 24'(Den)) r = 24'(Den);
    return r;
  endfunction

  always_comb begin
    thr   = 24'(cmd_i.thr) * 24'sd10;
    roll  = 24'(cmd_i.roll) * 24'sd10;
    pitch = 24'(cmd_i.pitch) * 24'sd10;
    yaw   = 24'(cmd_i.yaw) * 24'sd10;
    flap  = 24'(cmd_i.flap) * 24'sd10;
    tiltraw = 24'(cmd_i.tilt) * 24'sd10;
    diff  = 24'(cmd_i.roll) * 24'sd3 + 24'(cmd_i.yaw) * 24'sd3;
    hml   = clamp0(thr + diff);
    hmr   = clamp0(thr - diff);
    hp3   = 24'(cmd_i.pitch) * 24'sd3;
    hr5   = 24'(cmd_i.roll) * 24'sd5;
    hy5   = 24'(cmd_i.yaw) * 24'sd5;
    hp5   = 24'(cmd_i.pitch) * 24'sd5;
    cail  = clampn(roll + hp5);
    cair  = clampn(roll - hp5);
    n_h[0] = hml; n_h[1] = hmr; n_h[2] = hp3; n_h[3] = hp3;
    n_h[4] = hr5; n_h[5] = hr5; n_h[6] = hy5; n_h[7] = flap; n_h[8] = flap;
    n_c[0] = thr; n_c[1] = thr; n_c[2] = 24'(Den); n_c[3] = 24'(Den);
    n_c[4] = cail; n_c[5] = cair; n_c[6] = yaw; n_c[7] = flap; n_c[8] = flap;
    if (mode_e'(cmd_i.mode) == ModeTransition) begin
      n_h[2] = tiltraw; n_h[3] = tiltraw;
    end
  end

  logic signed [23:0] nh_q [NumCh];
  logic signed [23:0] nc_q [NumCh];
  logic [1:0]         mode_q [3];
  logic [FracBits:0]  t_q [3];
  logic [2:0]         vld_q;
  logic [FracBits:0]  t_c;

  assign t_c = (cmd_i.tilt < 0) ? '0 :
               (cmd_i.tilt > 16'(OneQ)) ? (FracBits+1)'(OneQ) : cmd_i.tilt[FracBits:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    nh_q <= n_h;
    nc_q <= n_c;
    mode_q[0] <= cmd_i.mode;
    mode_q[1] <= mode_q[0];
    mode_q[2] <= mode_q[1];
    t_q[0] <= t_c;
    t_q[1] <= t_q[0];
    t_q[2] <= t_q[1];
  end

  // stage 2-3: mapping
  logic [PW-1:0] h_us [NumCh];
  logic [PW-1:0] c_us [NumCh];
  logic [PW-1:0] h_us_q [NumCh];
  logic [PW-1:0] c_us_q [NumCh];
  logic [PW-1:0] ctr_us [NumCh];

  for (genvar m = 0; m < 2; m++) begin : g_motor
    logic [PW-1:0] mn, mx;
    logic signed [42:0] ph_q, pc_q;
    logic [PW-1:0] mn_q;
    assign mn = motor_cal_i[(2*m)*PW +: PW];
    assign mx = motor_cal_i[(2*m+1)*PW +: PW];
    always_ff @(posedge clk_i) begin
      ph_q <= 43'(nh_q[m]) * 43'($signed({1'b0, mx}) - $signed({1'b0, mn}));
      pc_q <= 43'(nc_q[m]) * 43'($signed({1'b0, mx}) - $signed({1'b0, mn}));
      mn_q <= mn;
    end
    logic signed [42:0] numh, numc;
    logic [25:0] ah, ac;
    logic [49:0] qh, qc;
    // numerator is never negative: shift by F+1, then reciprocal divide by five
    assign numh = 43'($signed({1'b0, mn_q})) * 43'(Den) + ph_q;
    assign numc = 43'($signed({1'b0, mn_q})) * 43'(Den) + pc_q;
    assign ah = 26'(numh >>> (FracBits + 1));
    assign ac = 26'(numc >>> (FracBits + 1));
    assign qh = ah * RecipFive;
    assign qc = ac * RecipFive;
    assign h_us[m] = qh[26 +: PW];
    assign c_us[m] = qc[26 +: PW];
  end

  for (genvar s = 2; s < NumCh; s++) begin : g_servo
    tam_servo #(.PulseBits(PulseBits)) u_h (
      .clk_i, .cal_i(servo_cal_i[s-1]), .n_i(nh_q[s]), .us_o(h_us[s]));
    tam_servo #(.PulseBits(PulseBits)) u_c (
      .clk_i, .cal_i(servo_cal_i[s-1]), .n_i(nc_q[s]), .us_o(c_us[s]));
  end

  always_comb begin
    ctr_us[0] = motor_cal_i[PW-1:0];
    ctr_us[1] = motor_cal_i[2*PW +: PW];
    for (int i = 2; i < NumCh; i++) ctr_us[i] = servo_cal_i[i-1][PW +: PW];
  end

  always_ff @(posedge clk_i) begin
    h_us_q <= h_us;
    c_us_q <= c_us;
  end

  // stage 4: blend and select
  logic [OutW-1:0] ch_q [NumCh];
  logic [OutW-1:0] ch_d [NumCh];
  logic [PW+FracBits+1:0] b;

  always_comb begin
    b = '0;
    for (int i = 0; i < NumCh; i++) begin
      b = (PW+FracBits+2)'((FracBits+1)'(OneQ) - t_q[2]) * (PW+FracBits+2)'(h_us_q[i])
        + (PW+FracBits+2)'(t_q[2]) * (PW+FracBits+2)'(c_us_q[i])
        + (PW+FracBits+2)'(OneQ / 2);
      unique case (mode_e'(mode_q[2]))
        ModeDisarmed:   ch_d[i] = OutW'(ctr_us[i]);
        ModeHover:      ch_d[i] = OutW'(h_us_q[i]);
        ModeCruise:     ch_d[i] = OutW'(c_us_q[i]);
        ModeTransition: ch_d[i] = OutW'(b >> FracBits);
        default:        ch_d[i] = '0;
      endcase
      if (mode_e'(mode_q[2]) == ModeTransition && (i == 2 || i == 3))
        ch_d[i] = OutW'(h_us_q[i]);
    end
  end

  always_ff @(posedge clk_i) ch_q <= ch_d;

  logic vld_out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_out_q <= 1'b0;
    else vld_out_q <= vld_q[2];
  end

  assign valid_o = vld_out_q;
  assign ch_o    = ch_q;
endmodule

>>> hw/rtl/tiltrotor_actuator_mixer.sv
// ----------------------------------------------------------------------------
// tiltrotor_actuator_mixer
// Mixes flight commands into nine actuator pulse widths.
// ----------------------------------------------------------------------------
// channel   direction  handshake         word
// command   in         start / busy      mode and six Q2.14 commands
// config    in         cfg_valid_i/ready register index and value
// result    out        done_o strobe     nine pulse widths (us)
//
// One word per cycle; done_o rises once the word has passed the front queue
// and the mix, map, blend and output stages.
// busy is always low; results cannot be stalled.
// Reset loads default calibration; config is always ready.
// ----------------------------------------------------------------------------
module tiltrotor_actuator_mixer import tam_pkg::*; #(
  parameter int unsigned PulseBits = PulseBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             mode_i,
  input  logic signed [15:0]     throttle_cmd_i,
  input  logic signed [15:0]     roll_cmd_i,
  input  logic signed [15:0]     pitch_cmd_i,
  input  logic signed [15:0]     yaw_cmd_i,
  input  logic signed [15:0]     flap_cmd_i,
  input  logic signed [15:0]     tilt_cmd_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IdxW-1:0]        cfg_index_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  output logic                   done_o,
  output logic [OutW-1:0]        motor_left_us_o,
  output logic [OutW-1:0]        motor_right_us_o,
  output logic [OutW-1:0]        tilt_left_us_o,
  output logic [OutW-1:0]        tilt_right_us_o,
  output logic [OutW-1:0]        aileron_left_us_o,
  output logic [OutW-1:0]        aileron_right_us_o,
  output logic [OutW-1:0]        rudder_us_o,
  output logic [OutW-1:0]        flap_left_us_o,
  output logic [OutW-1:0]        flap_right_us_o
);
  localparam int unsigned PW = PulseBits;
  localparam logic [4*PW-1:0] MotorRst =
    (4*PW)'(1000) | ((4*PW)'(2000) << PW) | ((4*PW)'(1000) << 2*PW) | ((4*PW)'(2000) << 3*PW);
  localparam logic [3*PW:0] ServoRst =
    (3*PW+1)'(1000) | ((3*PW+1)'(1500) << PW) | ((3*PW+1)'(2000) << 2*PW);

  logic [4*PW-1:0] motor_q;
  logic [3*PW:0]   servo_q [1:NumReg-1];

  assign cfg_ready_o = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_q <= MotorRst;
      for (int i = 1; i < NumReg; i++) servo_q[i] <= ServoRst;
    end else if (cfg_valid_i) begin
      if (reg_idx_e'(cfg_index_i) == RegMotor) motor_q <= cfg_data_i[4*PW-1:0];
      else servo_q[cfg_index_i] <= cfg_data_i[3*PW:0];
    end
  end

  cmd_t cmd_in, cmd_f;
  logic vld_f;

  assign cmd_in = '{mode: mode_i, thr: throttle_cmd_i, roll: roll_cmd_i,
                    pitch: pitch_cmd_i, yaw: yaw_cmd_i, flap: flap_cmd_i, tilt: tilt_cmd_i};

  tam_front u_front (
    .clk_i, .rst_ni, .push_i(start & ~busy), .cmd_i(cmd_in),
    .valid_o(vld_f), .cmd_o(cmd_f));

  logic [OutW-1:0] ch [NumCh];

  tam_back #(.PulseBits(PulseBits)) u_back (
    .clk_i, .rst_ni, .valid_i(vld_f), .cmd_i(cmd_f), .motor_cal_i(motor_q),
    .servo_cal_i(servo_q), .valid_o(done_o), .ch_o(ch));

  assign motor_left_us_o    = ch[0];
  assign motor_right_us_o   = ch[1];
  assign tilt_left_us_o     = ch[2];
  assign tilt_right_us_o    = ch[3];
  assign aileron_left_us_o  = ch[4];
  assign aileron_right_us_o = ch[5];
  assign rudder_us_o        = ch[6];
  assign flap_left_us_o     = ch[7];
  assign flap_right_us_o    = ch[8];
endmodule

>>> hw/rtl/tam_checker.sv
// ----------------------------------------------------------------------------
// tam_checker
// Port-level checks for the actuator mixer.
// ----------------------------------------------------------------------------
module tam_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_ready_o
);
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 done_o) else $error("result missing");
  a_nodone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 5)) else $error("spurious result");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o) else $error("config not ready");
endmodule

bind tiltrotor_actuator_mixer tam_checker u_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .cfg_ready_o);
